// ----- src/real_cosine_idft_macros.svh -----
// Assertion macros used by the real cosine inverse DFT controller.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef REAL_COSINE_IDFT_MACROS_SVH
`define REAL_COSINE_IDFT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RCID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define RCID_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCID_ASSERT_IMP(lbl, ante, cons, msg)
`define RCID_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/rcid_pkg.sv -----
// Shared types and constants of the real cosine inverse DFT block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package rcid_pkg;

    // Field widths of the item ports.
    localparam int IDX_W = 6;
    localparam int SMP_W = 16;

    // Default transform length.
    localparam int POINTS_DEF = 64;

    // Quotient bits of the rounded result before sign and saturation.
    localparam int QUOT_W = 16;

    // Cycles of the reciprocal multiplication that divides by the length.
    localparam int DIV_CYCLES = 1;

    // Cycles between the last memory read and a settled accumulator.
    localparam int DRAIN_CYCLES = 2;

    // Constants of the cosine table generator.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam int TAYLOR_TERMS = 10;

    // Function codes of an input item.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DRAIN,
        ST_PREP,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic start;
        logic issue;
        logic div_init;
        logic div_step;
        logic load_out;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/rcid_ctrl.sv -----
// Controller of the real cosine inverse DFT: sequences accumulation,
// rounding division and result delivery. Depends on rcid_pkg and the macros.
`default_nettype none
`include "real_cosine_idft_macros.svh"

module rcid_ctrl #(
    parameter int POINTS = rcid_pkg::POINTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         func,
    input  wire logic         out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output rcid_pkg::cmd_t    cmd
);

    localparam int CNT_A = $clog2(POINTS + 1);
    localparam int CNT_B = $clog2(rcid_pkg::DIV_CYCLES + 1);
    localparam int CW = (CNT_A > CNT_B) ? CNT_A : CNT_B;

    rcid_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic in_xfer;
    logic slot_free;

    assign in_xfer = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // State, counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcid_pkg::ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            rcid_pkg::ST_IDLE:
            begin
                if (in_xfer && func == rcid_pkg::FUNC_READ)
                begin
                    state_next = rcid_pkg::ST_ACCUM;
                    cnt_next = '0;
                end
            end
            rcid_pkg::ST_ACCUM:
            begin
                if (cnt_reg == CW'(POINTS - 1))
                begin
                    state_next = rcid_pkg::ST_DRAIN;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rcid_pkg::ST_DRAIN:
            begin
                if (cnt_reg == CW'(rcid_pkg::DRAIN_CYCLES - 1))
                begin
                    state_next = rcid_pkg::ST_PREP;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rcid_pkg::ST_PREP:
            begin
                state_next = rcid_pkg::ST_DIVIDE;
                cnt_next = '0;
            end
            rcid_pkg::ST_DIVIDE:
            begin
                if (cnt_reg == CW'(rcid_pkg::DIV_CYCLES - 1))
                begin
                    state_next = rcid_pkg::ST_DONE;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rcid_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = rcid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcid_pkg::ST_IDLE;
                cnt_next = '0;
            end
        endcase
    end

    // Commands, handshake outputs and the output valid flag.
    always_comb
    begin
        cmd = '0;
        in_ready = (state_reg == rcid_pkg::ST_IDLE);
        cmd.store = in_xfer && (func == rcid_pkg::FUNC_LOAD);
        cmd.start = in_xfer && (func == rcid_pkg::FUNC_READ);
        cmd.issue = (state_reg == rcid_pkg::ST_ACCUM);
        cmd.div_init = (state_reg == rcid_pkg::ST_PREP);
        cmd.div_step = (state_reg == rcid_pkg::ST_DIVIDE);
        cmd.load_out = (state_reg == rcid_pkg::ST_DONE) && slot_free;
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is only written into a free or departing output slot.
    `RCID_ASSERT_IMP(a_load_slot_free, cmd.load_out, !out_valid_reg || out_ready,
        "result loaded over a waiting result")
    // A read transfer starts accumulation in the next cycle.
    `RCID_ASSERT_NXT(a_start_accum, cmd.start, state_reg == rcid_pkg::ST_ACCUM,
        "read transfer did not start accumulation")
    // Accumulation issues exactly one pass over the samples.
    `RCID_ASSERT_NXT(a_accum_len,
        state_reg == rcid_pkg::ST_ACCUM && cnt_reg == CW'(POINTS - 1),
        state_reg == rcid_pkg::ST_DRAIN, "accumulation pass has the wrong length")
    // A new result only follows the final state of a read.
    `RCID_ASSERT_IMP(a_valid_source, $rose(out_valid_reg),
        $past(state_reg == rcid_pkg::ST_DONE), "result raised outside the done state")

endmodule

`default_nettype wire

// ----- src/rcid_datapath.sv -----
// Datapath of the real cosine inverse DFT: sample memory, cosine table,
// multiply-accumulate pipeline and rounding stage. Depends on rcid_pkg.
`default_nettype none

module rcid_datapath #(
    parameter int POINTS = rcid_pkg::POINTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rcid_pkg::cmd_t                    cmd,
    input  wire logic signed [rcid_pkg::SMP_W-1:0] sample,
    input  wire logic        [rcid_pkg::IDX_W-1:0] index,
    output logic signed      [rcid_pkg::SMP_W-1:0] value,
    output logic             [rcid_pkg::IDX_W-1:0] out_index
);

    localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int PW = $clog2(POINTS + 1);
    localparam int ACCW = 32 + AW;
    localparam int RW = PW + 16;
    localparam int QW = rcid_pkg::QUOT_W;
    localparam int SH = RW + AW;
    localparam int IDX_N = 1 << rcid_pkg::IDX_W;
    localparam logic [ACCW:0] HALF_DEN = (ACCW + 1)'(POINTS) << 14;

    typedef logic signed [15:0] cos_rom_t [POINTS];
    typedef logic [AW-1:0] kmod_rom_t [IDX_N];

    // Q1.15 cosine of a table position, from a range-reduced Taylor series.
    function automatic logic signed [15:0] cos_entry(input int m);
        logic [63:0] q4;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] t;
        logic [63:0] mag;
        logic signed [63:0] v;
        q4 = 64'(4 * m);
        quad = q4 / POINTS;
        rem = q4 % POINTS;
        x = (rcid_pkg::HALF_PI_Q30 * rem) / POINTS;
        x2 = (x * x) >> 30;
        acc = rcid_pkg::ONE_Q30;
        for (int k = rcid_pkg::TAYLOR_TERMS; k >= 1; k--)
        begin
            if (quad[0] == 1'b0)
            begin
                t = ((x2 * acc) >> 30) / 64'((2 * k - 1) * (2 * k));
            end
            else
            begin
                t = ((x2 * acc) >> 30) / 64'((2 * k) * (2 * k + 1));
            end
            acc = (t > rcid_pkg::ONE_Q30) ? 64'd0 : rcid_pkg::ONE_Q30 - t;
        end
        mag = (quad[0] == 1'b0) ? acc : ((x * acc) >> 30);
        mag = (mag + 64'd16384) >> 15;
        v = signed'(mag);
        if (quad == 64'd1 || quad == 64'd2)
        begin
            v = -v;
        end
        if (v > 64'sd32767)
        begin
            v = 64'sd32767;
        end
        if (v < -64'sd32768)
        begin
            v = -64'sd32768;
        end
        return v[15:0];
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int m = 0; m < POINTS; m++)
        begin
            rom[m] = cos_entry(m);
        end
        return rom;
    endfunction

    // Bin number reduced modulo the transform length.
    function automatic kmod_rom_t build_kmod_rom();
        kmod_rom_t rom;
        for (int i = 0; i < IDX_N; i++)
        begin
            rom[i] = AW'(i % POINTS);
        end
        return rom;
    endfunction

    // Rounded-up reciprocal of the length; exact for every RW-bit dividend.
    function automatic logic [RW:0] build_recip();
        logic [63:0] num;
        num = 64'd1 << SH;
        return (RW + 1)'((num + 64'(POINTS) - 64'd1) / 64'(POINTS));
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();
    localparam kmod_rom_t KMOD_ROM = build_kmod_rom();
    localparam logic [RW:0] RECIP = build_recip();

    logic signed [15:0] sample_mem [POINTS];
    logic signed [15:0] smp_rd_reg;
    logic signed [15:0] cos_rd_reg;
    logic signed [31:0] prod_reg;
    logic v1_reg, v2_reg;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] j_reg;
    logic [AW-1:0] m_reg, m_next;
    logic [AW:0] m_sum;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic [ACCW-1:0] acc_mag;
    logic [ACCW:0] round_sum;
    logic [RW-1:0] rem_reg, rem_next;
    logic [2*RW:0] quot_prod;
    logic [QW-1:0] quot_reg, quot_next;
    logic neg_reg;
    logic [rcid_pkg::IDX_W-1:0] idx_reg;
    logic signed [15:0] value_reg, value_next;
    logic [rcid_pkg::IDX_W-1:0] out_index_reg;
    logic load_in_range;

    assign load_in_range = 32'(index) < 32'(POINTS);

    // Sample memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.store && load_in_range)
        begin
            sample_mem[AW'(index)] <= sample;
        end
        if (cmd.issue)
        begin
            smp_rd_reg <= sample_mem[j_reg];
            cos_rd_reg <= COS_ROM[m_reg];
        end
    end

    // Table position steps by the bin number, modulo the length.
    always_comb
    begin
        m_sum = {1'b0, m_reg} + {1'b0, k_reg};
        if (m_sum >= (AW + 1)'(POINTS))
        begin
            m_next = AW'(m_sum - (AW + 1)'(POINTS));
        end
        else
        begin
            m_next = m_sum[AW-1:0];
        end
    end

    // Read address, bin and position registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            k_reg <= KMOD_ROM[index];
            idx_reg <= index;
            j_reg <= '0;
            m_reg <= '0;
        end
        else if (cmd.issue)
        begin
            j_reg <= j_reg + 1'b1;
            m_reg <= m_next;
        end
    end

    // Valid flags of the multiply-accumulate pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    // Product stage and exact accumulation of the Q2.30 products.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.start)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + {{(ACCW - 32){prod_reg[31]}}, prod_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= smp_rd_reg * cos_rd_reg;
        acc_reg <= acc_next;
    end

    // Magnitude plus half a divisor, scaled so the divisor is the length.
    assign acc_mag = acc_reg[ACCW-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign round_sum = {1'b0, acc_mag} + HALF_DEN;

    // Division by the length as a multiplication by its reciprocal.
    assign quot_prod = {{(RW + 1){1'b0}}, rem_reg} * {{RW{1'b0}}, RECIP};

    always_comb
    begin
        rem_next = rem_reg;
        quot_next = quot_reg;
        if (cmd.div_init)
        begin
            rem_next = round_sum[RW+14:15];
        end
        else if (cmd.div_step)
        begin
            quot_next = quot_prod[SH+QW-1:SH];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quot_reg <= quot_next;
        if (cmd.div_init)
        begin
            neg_reg <= acc_reg[ACCW-1];
        end
    end

    // Sign and saturation of the rounded quotient.
    always_comb
    begin
        if (neg_reg)
        begin
            value_next = 16'(~quot_reg + 1'b1);
        end
        else if (quot_reg[QW-1])
        begin
            value_next = 16'sh7FFF;
        end
        else
        begin
            value_next = 16'(quot_reg);
        end
    end

    // Output register, loaded only when the result slot is free.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            value_reg <= value_next;
            out_index_reg <= idx_reg;
        end
    end

    assign value = value_reg;
    assign out_index = out_index_reg;

endmodule

`default_nettype wire

// ----- src/real_cosine_idft.sv -----
// A read runs one pass of the shared multiply-accumulate over the sample memory
// and a rounding divide; no new item is taken until its result enters the output
// slot. Loads transfer one per cycle while idle. Reset clears control state only;
// the sample store is not cleared and holds unknown data until loaded.
// Top level: joins the controller and the datapath. Depends on rcid_pkg.
`default_nettype none

module real_cosine_idft #(
    parameter int POINTS = rcid_pkg::POINTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              func,
    input  wire logic signed [rcid_pkg::SMP_W-1:0] sample,
    input  wire logic        [rcid_pkg::IDX_W-1:0] index,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed      [rcid_pkg::SMP_W-1:0] value,
    output logic             [rcid_pkg::IDX_W-1:0] out_index
);

    rcid_pkg::cmd_t cmd;

    // Sequencer for loads, accumulation, division and delivery.
    rcid_ctrl #(
        .POINTS(POINTS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .func(func),
        .out_ready(out_ready),
        .in_ready(in_ready),
        .out_valid(out_valid),
        .cmd(cmd)
    );

    // Storage and arithmetic.
    rcid_datapath #(
        .POINTS(POINTS)
    ) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sample(sample),
        .index(index),
        .value(value),
        .out_index(out_index)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the real cosine inverse DFT block: loads and bin reads with
// random gaps on both channels, checked against a bit-exact predictor of the transform.
// Depends on rcid_pkg and the real_cosine_idft top level.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W         = rcid_pkg::SMP_W;
    localparam int IDX_W         = rcid_pkg::IDX_W;
    localparam int NPTS          = rcid_pkg::POINTS_DEF;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 2 * (NPTS + 21);
    localparam int READ_PERCENT  = 35;

    // Sample patterns used to fill the whole store in the directed part.
    typedef enum {FILL_MAX, FILL_MIN, FILL_ALT, FILL_ZERO} fill_t;

    // One expected bin read result.
    typedef struct {
        logic signed [SMP_W-1:0] value;
        logic        [IDX_W-1:0] bin;
    } bin_result_t;

    // Predicts the transform and holds the bin results still owed by the block.
    class idft_scoreboard;
        int                      cos_q15 [NPTS];
        logic signed [SMP_W-1:0] samples [NPTS];
        bin_result_t             pending_bins [$];
        int                      errors;

        function new();
            errors = 0;
            for (int m = 0; m < NPTS; m++)
            begin
                cos_q15[m] = cosine_entry(m);
                samples[m] = '0;
            end
        endfunction

        // Q1.15 cosine of 2*pi*m/NPTS from the quadrant and a Taylor series in Q2.30.
        function int cosine_entry(int m);
            logic [63:0] q4;
            logic [63:0] rem;
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] acc;
            logic [63:0] t;
            logic [63:0] mag;
            int          quad;
            int          v;
            q4   = 64'(4 * (m % NPTS));
            quad = int'(q4 / NPTS);
            rem  = q4 % NPTS;
            x    = (rcid_pkg::HALF_PI_Q30 * rem) / NPTS;
            x2   = (x * x) >> 30;
            acc  = rcid_pkg::ONE_Q30;
            for (int k = rcid_pkg::TAYLOR_TERMS; k >= 1; k--)
            begin
                if (quad % 2 == 0)
                    t = ((x2 * acc) >> 30) / 64'((2 * k - 1) * (2 * k));
                else
                    t = ((x2 * acc) >> 30) / 64'((2 * k) * (2 * k + 1));
                acc = (t > rcid_pkg::ONE_Q30) ? 64'd0 : rcid_pkg::ONE_Q30 - t;
            end
            mag = (quad % 2 == 0) ? acc : ((x * acc) >> 30);
            mag = (mag + 64'd16384) >> 15;
            v = int'(mag);
            if (quad == 1 || quad == 2)
                v = -v;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v;
        endfunction

        // A load updates the store; a read queues the rounded, saturated bin value.
        function void note_input(logic f, logic signed [SMP_W-1:0] s,
                                 logic [IDX_W-1:0] idx);
            longint      sum;
            logic [63:0] mag;
            logic [63:0] q;
            logic [63:0] den;
            longint      v;
            bin_result_t r;
            if (f == rcid_pkg::FUNC_LOAD)
            begin
                if (int'(idx) < NPTS)
                    samples[idx] = s;
                return;
            end
            sum = 0;
            for (int j = 0; j < NPTS; j++)
                sum += longint'(samples[j]) * longint'(cos_q15[int'((j * idx) % NPTS)]);
            mag = (sum < 0) ? 64'(-sum) : 64'(sum);
            den = 64'(NPTS) << 15;
            q   = (2 * mag + den) / (2 * den);
            v   = longint'(q);
            if (sum < 0)
                v = -v;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            r.value = SMP_W'(v);
            r.bin   = idx;
            pending_bins.push_back(r);
        endfunction

        // Compares one output transfer with the oldest owed bin result.
        task check_result(logic signed [SMP_W-1:0] got, logic [IDX_W-1:0] bin);
            bin_result_t e;
            if (pending_bins.size() == 0)
            begin
                report($sformatf("result with no read pending: value %0d bin %0d", got, bin));
                return;
            end
            e = pending_bins.pop_front();
            if (got !== e.value)
                report($sformatf("bin %0d value %0d, predicted %0d", e.bin, got, e.value));
            if (bin !== e.bin)
                report($sformatf("out_index %0d, predicted %0d", bin, e.bin));
        endtask

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function int outstanding();
            return pending_bins.size();
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    func      = rcid_pkg::FUNC_LOAD;
    logic signed [SMP_W-1:0] sample    = '0;
    logic        [IDX_W-1:0] index     = '0;
    logic                    out_ready = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    logic signed [SMP_W-1:0] value;
    logic        [IDX_W-1:0] out_index;

    bit             calm        = 1'b0;
    int             idle_cycles = 0;
    int             sink_hold   = 0;
    idft_scoreboard sb;

    real_cosine_idft uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .sample    (sample),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .out_index (out_index)
    );

    always #4 clk = ~clk;

    // Idle length: mostly none or short, now and then long; none during calm stretches.
    function int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Sample values weighted toward the extremes, zero and minus one.
    function logic signed [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function logic [IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return IDX_W'(NPTS - 1);
        return IDX_W'($urandom_range(0, NPTS - 1));
    endfunction

    // Presents one item, waits for its transfer, then idles for a random gap.
    task send_item(logic f, logic signed [SMP_W-1:0] s, logic [IDX_W-1:0] idx);
        int gap;
        in_valid <= 1'b1;
        func     <= f;
        sample   <= s;
        index    <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(f, s, idx);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the input side until every owed bin result has come back.
    task drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    task fill_store(fill_t kind);
        logic signed [SMP_W-1:0] s;
        for (int j = 0; j < NPTS; j++)
        begin
            case (kind)
                FILL_MAX: s = 16'sh7FFF;
                FILL_MIN: s = 16'sh8000;
                FILL_ALT: s = (j % 2 == 0) ? 16'sh7FFF : 16'sh8000;
                default:  s = 16'sh0000;
            endcase
            send_item(rcid_pkg::FUNC_LOAD, s, IDX_W'(j));
        end
    endtask

    task read_bin(int k);
        send_item(rcid_pkg::FUNC_READ, pick_sample(), IDX_W'(k));
    endtask

    // Output side: check each result transfer and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(value, out_index);
        if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
            sink_hold = pick_gap();
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus: directed fills and reads, then a random mix of loads and reads.
    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-scale positive store; lowest, next and highest bins.
        fill_store(FILL_MAX);
        read_bin(0);
        read_bin(1);
        read_bin(NPTS - 1);
        drain_results();

        // Full-scale negative store; the half-turn bin lands on a tie that rounds away.
        fill_store(FILL_MIN);
        read_bin(NPTS / 2);
        read_bin(0);

        // Alternating extremes; the half-turn bin reaches full scale.
        fill_store(FILL_ALT);
        read_bin(NPTS / 2);
        read_bin(NPTS / 4);
        read_bin(0);

        // Two isolated samples in an empty store.
        fill_store(FILL_ZERO);
        send_item(rcid_pkg::FUNC_LOAD, 16'sh7FFF, IDX_W'(5));
        send_item(rcid_pkg::FUNC_LOAD, 16'sh8000, IDX_W'(NPTS - 1));
        read_bin(0);
        read_bin(5);
        read_bin(31);
        drain_results();

        // Random mix; the store is fully written from here on.
        repeat (RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 199) == 0)
                calm = ~calm;
            if ($urandom_range(0, 299) == 0)
                drain_results();
            if ($urandom_range(0, 99) < READ_PERCENT)
                send_item(rcid_pkg::FUNC_READ, pick_sample(), pick_index());
            else
                send_item(rcid_pkg::FUNC_LOAD, pick_sample(), pick_index());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report("reads left without a result");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
